// ===== hdl/pwq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwq_pkg: shared constants and types for the position weighted quantizer
// Register indexes, fixed-point widths and the cell word that moves along
// the divider chain.
// ----------------------------------------------------------------------------
package pwq_pkg;

	localparam int DIM_MAX_DEF     = 16;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int OUT_BITS        = 48;
	localparam int CFG_W           = 16;
	localparam int POS_W           = 4;
	localparam int SUM_W           = 25;
	localparam int STEP_W          = 41;
	localparam int QUO_W           = 48;
	localparam int STEP_ONE        = 65536;
	localparam int SUM_BASE        = 1024;

	localparam logic [2:0] REG_QP = 3'd0;
	localparam logic [2:0] REG_WX = 3'd1;
	localparam logic [2:0] REG_WY = 3'd2;
	localparam logic [2:0] REG_WU = 3'd3;
	localparam logic [2:0] REG_WV = 3'd4;

	localparam logic REQ_FWD = 1'b0;
	localparam logic REQ_INV = 1'b1;

	// word carried from cell to cell: one item in flight
	typedef struct packed {
		logic              vld;
		logic              inv;
		logic              neg;
		logic              sat;
		logic [STEP_W-1:0] step;
		logic [STEP_W:0]   rem;
		logic [QUO_W-1:0]  acc;
	} cell_t;

endpackage

// ===== hdl/pwq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwq_cell: one restoring division step
// Shift the next dividend bit into the partial remainder, subtract the step
// where it fits, and hand the word on. Inverse words pass through untouched.
// ----------------------------------------------------------------------------
module pwq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  pwq_pkg::cell_t din,
	output pwq_pkg::cell_t dout
);
	import pwq_pkg::*;

	logic [STEP_W+1:0] trial;
	logic [STEP_W:0]   rem_sh;
	logic              dbit;
	cell_t             nxt;

	// form the step on the top dividend bit of acc
	always_comb begin
		dbit   = din.acc[QUO_W-1];
		rem_sh = {din.rem[STEP_W-1:0], dbit};
		trial  = {1'b0, rem_sh} - {2'b0, din.step};
		nxt    = din;
		if (!din.inv) begin
			if (!trial[STEP_W+1]) begin
				nxt.rem = trial[STEP_W:0];
				nxt.acc = {din.acc[QUO_W-2:0], 1'b1};
			end else begin
				nxt.rem = rem_sh;
				nxt.acc = {din.acc[QUO_W-2:0], 1'b0};
			end
		end
	end

	// advance when the pipe moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== hdl/pwq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwq_front: step generation and inverse product
// Three stages: weighted position sum, then qp times sum with clamp, then the
// inverse product split into two partial products before the cell chain.
// ----------------------------------------------------------------------------
module pwq_front #(
	parameter int DIM_MAX     = pwq_pkg::DIM_MAX_DEF,
	parameter int SAMPLE_BITS = pwq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic                          req_type,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic [pwq_pkg::POS_W-1:0]     pos_x,
	input  logic [pwq_pkg::POS_W-1:0]     pos_y,
	input  logic [pwq_pkg::POS_W-1:0]     pos_u,
	input  logic [pwq_pkg::POS_W-1:0]     pos_v,
	input  logic [pwq_pkg::CFG_W-1:0]     qp,
	input  logic [pwq_pkg::CFG_W-1:0]     wx,
	input  logic [pwq_pkg::CFG_W-1:0]     wy,
	input  logic [pwq_pkg::CFG_W-1:0]     wu,
	input  logic [pwq_pkg::CFG_W-1:0]     wv,
	output pwq_pkg::cell_t                dout
);
	import pwq_pkg::*;

	localparam logic [POS_W-1:0] PMAX = POS_W'(DIM_MAX - 1);

	function automatic logic [POS_W-1:0] clampp(input logic [POS_W-1:0] p);
		if (DIM_MAX < 16 && p > PMAX) return PMAX;
		return p;
	endfunction

	logic [POS_W-1:0]       cx, cy, cu, cv;
	logic [SAMPLE_BITS-1:0] raw, magn;
	logic                   negc;
	logic                   vld_s1, inv_s1, neg_s1, zero_s1;
	logic [SUM_W-1:0]       sum_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;
	logic                   vld_s2, inv_s2, neg_s2;
	logic [STEP_W-1:0]      step_s2;
	logic [SAMPLE_BITS-1:0] mag_s2;
	logic [STEP_W-1:0]      prod;
	logic [63:0]            phi;
	logic [63:0]            plo;
	logic [63:0]            res;
	logic [63:0]            lim;
	cell_t                  w;

	// clamp positions, take the magnitude
	always_comb begin
		cx   = clampp(pos_x);
		cy   = clampp(pos_y);
		cu   = clampp(pos_u);
		cv   = clampp(pos_v);
		raw  = sample_value;
		negc = raw[SAMPLE_BITS-1];
		magn = negc ? (~raw + 1'b1) : raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: weighted sum of positions
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1  <= req_type;
			neg_s1  <= negc;
			zero_s1 <= (cx == '0) && (cy == '0) && (cu == '0) && (cv == '0);
			mag_s1  <= magn;
			sum_s1  <= SUM_W'(SUM_BASE) + SUM_W'(wx) * SUM_W'(cx)
				+ SUM_W'(wy) * SUM_W'(cy) + SUM_W'(wu) * SUM_W'(cu)
				+ SUM_W'(wv) * SUM_W'(cv);
		end
	end

	// stage 2: step = qp * sum, raised to at least 1.0; zero position gives 1.0
	always_comb prod = STEP_W'(qp) * STEP_W'(sum_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s2  <= inv_s1;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			step_s2 <= (zero_s1 || prod < STEP_W'(STEP_ONE)) ? STEP_W'(STEP_ONE) : prod;
		end
	end

	// inverse product: mag*hi + (mag*lo >> 16), then saturate; forward words carry mag << 16
	always_comb begin
		phi = 64'(mag_s2) * 64'(step_s2[STEP_W-1:16]);
		plo = 64'(mag_s2) * 64'(step_s2[15:0]);
		res = phi + (plo >> 16);
		lim = neg_s2 ? (64'd1 << 47) : (64'd1 << 47) - 64'd1;
		w      = '0;
		w.vld  = vld_s2;
		w.inv  = inv_s2;
		w.neg  = neg_s2;
		w.step = step_s2;
		if (inv_s2) begin
			if (res > lim) begin
				w.acc = lim[47:0];
				w.sat = 1'b1;
			end else begin
				w.acc = res[47:0];
			end
		end else begin
			w.acc = QUO_W'(mag_s2) << 16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= w;
		end
	end

endmodule

// ===== hdl/position_weighted_4d_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_weighted_4d_quantizer: frequency weighted dead-zone quantizer
// Channel   | handshake         | word
// in        | in_valid/in_stall | req_type, sample_value, pos_x..pos_v
// out       | out_valid/out_stall | result_value, saturated
// cfg       | cfg_valid/cfg_ready | cfg_index, cfg_data
// One word per cycle while the output is not stalled; the path is 3 front
// stages, then 48 restoring division cells, then the output register.
// Reset clears valid bits and loads the configuration registers with 256.
// A stalled output freezes the whole pipe, and the input is stalled for
// exactly the cycles in which the output word is held.
// ----------------------------------------------------------------------------
module position_weighted_4d_quantizer #(
	parameter int DIM_MAX     = pwq_pkg::DIM_MAX_DEF,
	parameter int SAMPLE_BITS = pwq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic signed [SAMPLE_BITS-1:0]   sample_value,
	input  logic [pwq_pkg::POS_W-1:0]       pos_x,
	input  logic [pwq_pkg::POS_W-1:0]       pos_y,
	input  logic [pwq_pkg::POS_W-1:0]       pos_u,
	input  logic [pwq_pkg::POS_W-1:0]       pos_v,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [pwq_pkg::OUT_BITS-1:0] result_value,
	output logic                            saturated,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [pwq_pkg::CFG_W-1:0]       cfg_data
);
	import pwq_pkg::*;

	logic [CFG_W-1:0] qp_q, wx_q, wy_q, wu_q, wv_q;
	logic             en;
	cell_t            chain [0:QUO_W];
	logic [QUO_W-1:0] mag;

	// pipe moves unless a finished word is held
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qp_q <= CFG_W'(256);
			wx_q <= CFG_W'(256);
			wy_q <= CFG_W'(256);
			wu_q <= CFG_W'(256);
			wv_q <= CFG_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_QP:  qp_q <= cfg_data;
				REG_WX:  wx_q <= cfg_data;
				REG_WY:  wy_q <= cfg_data;
				REG_WU:  wu_q <= cfg_data;
				REG_WV:  wv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pwq_front #(.DIM_MAX(DIM_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .en,
		.in_vld(in_valid), .req_type, .sample_value,
		.pos_x, .pos_y, .pos_u, .pos_v,
		.qp(qp_q), .wx(wx_q), .wy(wy_q), .wu(wu_q), .wv(wv_q),
		.dout(chain[0])
	);

	// row of division cells
	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		pwq_cell u_cell (.clk, .arst_n, .en, .din(chain[i]), .dout(chain[i+1]));
	end

	// output register: apply the sign
	always_comb mag = chain[QUO_W].acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= chain[QUO_W].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_value <= chain[QUO_W].neg ? (~mag + 1'b1) : mag;
			saturated    <= chain[QUO_W].sat;
		end
	end

endmodule

// ===== hdl/pwq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwq_checker: port level checks
// Watch the output handshake and the stall behaviour seen at the ports.
// ----------------------------------------------------------------------------
module pwq_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic                   saturated,
	input logic [pwq_pkg::OUT_BITS-1:0] result_value
);
	import pwq_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(saturated))
		else $error("stalled result changed");

	// input stalls only while the output is held
	a_istall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// saturation only ever on extreme values
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> result_value == {1'b0, {(OUT_BITS-1){1'b1}}}
		|| result_value == {1'b1, {(OUT_BITS-1){1'b0}}})
		else $error("saturated flag on a non-limit value");

endmodule

bind position_weighted_4d_quantizer pwq_checker u_pwq_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .saturated, .result_value
);

// ===== verif/position_weighted_4d_quantizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_weighted_4d_quantizer_tb: self-checking bench for the quantizer
// Drives sample and position words with random gaps and output stalls.
// Every accepted word is run through a bit-exact model of the step, division
// and saturation, and each output word is compared with the oldest
// prediction. Several register settings are used, the extremes among them.
// ----------------------------------------------------------------------------
module position_weighted_4d_quantizer_tb;
	import pwq_pkg::*;

	localparam int  LATENCY   = 60;
	localparam int  MAX_CYC   = 400000;
	localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;

	typedef struct packed {
		logic        inv;
		logic [23:0] smp;
		logic [3:0]  px, py, pu, pv;
	} quant_word_t;

	typedef struct packed {
		logic [47:0] value;
		logic        sat;
	} quant_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic signed [23:0] sample_value = '0;
	logic [3:0] pos_x = '0, pos_y = '0, pos_u = '0, pos_v = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [47:0] result_value;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// register copies used for prediction
	logic [15:0] qp_q = 16'd256, wx_q = 16'd256, wy_q = 16'd256;
	logic [15:0] wu_q = 16'd256, wv_q = 16'd256;

	quant_res_t expected_q[$];
	int  mismatches = 0;
	int  words_sent = 0;
	int  words_checked = 0;
	int  cycle_cnt = 0;
	bit  idle_on = 1'b1;
	int  hold_req = 0;

	position_weighted_4d_quantizer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .sample_value(sample_value),
		.pos_x(pos_x), .pos_y(pos_y), .pos_u(pos_u), .pos_v(pos_v),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// step for a position, Q.16, never below 1.0
	function automatic logic [63:0] weighted_step(quant_word_t w);
		logic [63:0] sum, st;
		if (w.px == 0 && w.py == 0 && w.pu == 0 && w.pv == 0)
			return 64'd65536;
		sum = 64'd1024 + 64'(wx_q) * w.px + 64'(wy_q) * w.py
			+ 64'(wu_q) * w.pu + 64'(wv_q) * w.pv;
		st = 64'(qp_q) * sum;
		if (st < 64'd65536)
			st = 64'd65536;
		return st;
	endfunction

	function automatic quant_res_t predict_quant(quant_word_t w);
		quant_res_t  r;
		logic        neg;
		logic [23:0] m24;
		logic [63:0] mag, st, res;
		neg = w.smp[23];
		m24 = ~w.smp + 24'd1;
		mag = neg ? 64'(m24) : 64'(w.smp);
		if (neg && mag == 0)
			mag = 64'h80_0000;
		st = weighted_step(w);
		r.sat = 1'b0;
		if (w.inv == REQ_FWD) begin
			res = (mag << 16) / st;
		end else begin
			res = mag * (st >> 16) + ((mag * (st & 64'hFFFF)) >> 16);
			if (!neg && res > 64'(POS_LIM)) begin
				res = 64'(POS_LIM);
				r.sat = 1'b1;
			end else if (neg && res > 64'(POS_LIM) + 1) begin
				res = 64'(POS_LIM) + 1;
				r.sat = 1'b1;
			end
		end
		if (neg)
			res = ~res + 64'd1;
		r.value = res[47:0];
		return r;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > MAX_CYC) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stalls: random bursts, or a long hold on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req  <= hold_req - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 16) - 1) @(posedge clk);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// check each output word against the oldest prediction
	always @(posedge clk) begin
		quant_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			words_checked <= words_checked + 1;
			if (expected_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("Unexpected word: value %0d sat %0b", result_value, saturated);
			end else begin
				e = expected_q.pop_front();
				if (result_value !== e.value || saturated !== e.sat) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("Mismatch: expected %0d/%0b, got %0d/%0b",
							$signed(e.value), e.sat, result_value, saturated);
				end
			end
		end
	end

	// offer one word; valid stays up so the next word can follow at once
	task automatic send_word(quant_word_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= w.inv;
		sample_value <= w.smp;
		pos_x <= w.px; pos_y <= w.py; pos_u <= w.pu; pos_v <= w.pv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(predict_quant(w));
		words_sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_QP: qp_q = val;
			REG_WX: wx_q = val;
			REG_WY: wy_q = val;
			REG_WU: wu_q = val;
			REG_WV: wv_q = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] qp, logic [15:0] wx, logic [15:0] wy,
		logic [15:0] wu, logic [15:0] wv);
		wait_drain();
		write_reg(REG_QP, qp);
		write_reg(REG_WX, wx);
		write_reg(REG_WY, wy);
		write_reg(REG_WU, wu);
		write_reg(REG_WV, wv);
	endtask

	function automatic quant_word_t random_word();
		quant_word_t w;
		w.inv = $urandom_range(0, 1);
		case ($urandom_range(0, 4))
			0: w.smp = $urandom_range(0, 255);
			1: w.smp = -24'($urandom_range(0, 255));
			2: w.smp = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
			default: w.smp = $urandom;
		endcase
		w.px = $urandom; w.py = $urandom; w.pu = $urandom; w.pv = $urandom;
		if ($urandom_range(0, 7) == 0)
			{w.px, w.py, w.pu, w.pv} = '0;
		return w;
	endfunction

	// extremes of sample and position, both directions, overflow, small step
	task automatic test_directed();
		quant_word_t w;
		logic [23:0] smp_set[6] = '{24'd0, 24'd1, 24'h7F_FFFF, 24'h80_0000,
			24'hFF_FFFF, 24'd1000};
		foreach (smp_set[i]) begin
			w = '{REQ_FWD, smp_set[i], 4'd0, 4'd0, 4'd0, 4'd0};
			send_word(w);
			w = '{REQ_INV, smp_set[i], 4'd15, 4'd15, 4'd15, 4'd15};
			send_word(w);
		end
		w = '{REQ_FWD, 24'd12345, 4'd15, 4'd0, 4'd7, 4'd1};
		send_word(w);
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		foreach (smp_set[i]) begin
			w = '{REQ_INV, smp_set[i], 4'd15, 4'd15, 4'd15, 4'd15};
			send_word(w);
		end
		w = '{REQ_FWD, 24'h7F_FFFF, 4'd15, 4'd15, 4'd15, 4'd15};
		send_word(w);
		// qp zero and zero weights force the step up to 1.0
		set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		w = '{REQ_FWD, 24'h80_0000, 4'd3, 4'd2, 4'd1, 4'd9};
		send_word(w);
		w = '{REQ_INV, 24'h7F_FFFF, 4'd3, 4'd2, 4'd1, 4'd9};
		send_word(w);
		// unknown register index leaves everything as it is
		wait_drain();
		write_reg(3'd7, 16'h1234);
		write_reg(3'd5, 16'h5678);
		send_word('{REQ_FWD, 24'd777, 4'd1, 4'd1, 4'd1, 4'd1});
	endtask

	task automatic test_random(int n);
		repeat (n) send_word(random_word());
	endtask

	// long output hold while the sender keeps offering words
	task automatic test_backpressure();
		hold_req = 300;
		test_random(120);
		wait_drain();
		test_random(30);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_regs(16'd256, 16'd256, 16'd256, 16'd256, 16'd256);
		test_random(200);
		set_regs(16'd64, 16'd13, 16'd300, 16'd0, 16'd40);
		test_random(200);
		test_backpressure();
		set_regs(16'hFFFF, 16'd1, 16'hFFFF, 16'd255, 16'h8000);
		test_random(200);
		set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
		idle_on = 1'b0;
		test_random(150);
		wait_drain();
		$display("Covered %0d words (%0d checked) over seven register settings,",
			words_sent, words_checked);
		$display("both directions, saturation, zero position and output hold.");
		if (mismatches == 0 && expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== position_weighted_4d_quantizer.f =====
hdl/pwq_pkg.sv
hdl/pwq_cell.sv
hdl/pwq_front.sv
hdl/position_weighted_4d_quantizer.sv
hdl/pwq_checker.sv
verif/position_weighted_4d_quantizer_tb.sv
